[hdl/cdq_pkg.sv]
// shared types and constants of the circular deque core
// no dependencies; used by every module of the block
package cdq_pkg;

	localparam int DEPTH  = 32;
	localparam int WORD_W = 32;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W  = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_PEEK_BACK  = 3'd4,
		CMD_PEEK_FRONT = 3'd5,
		CMD_SIZE       = 3'd6,
		CMD_LIST       = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		MODE_HOLD,
		MODE_WRITE,
		MODE_SHIFT_UP,
		MODE_SHIFT_DOWN,
		MODE_ROTATE
	} mode_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		mode_t                     mode;
		logic [IDX_W-1:0]          sel;
		logic signed [WORD_W-1:0]  value;
	} cell_ctl_t;

endpackage

[hdl/cdq_cell.sv]
// one storage cell of the deque chain: holds one word and trades it with its neighbors
// depends on cdq_pkg
module cdq_cell (
	input  logic                              clk,
	input  cdq_pkg::cell_ctl_t                ctl,
	input  logic [cdq_pkg::IDX_W-1:0]         idx,
	input  logic signed [cdq_pkg::WORD_W-1:0] prev_data,
	input  logic signed [cdq_pkg::WORD_W-1:0] next_data,
	input  logic signed [cdq_pkg::WORD_W-1:0] head_data,
	output logic signed [cdq_pkg::WORD_W-1:0] data
);

	logic signed [cdq_pkg::WORD_W-1:0] data_q;
	logic                              hit;

	assign hit  = (idx == ctl.sel);
	assign data = data_q;

	always_ff @(posedge clk) begin
		case (ctl.mode)
			cdq_pkg::MODE_WRITE: begin
				if (hit) begin
					data_q <= ctl.value;
				end
			end
			cdq_pkg::MODE_SHIFT_UP:   data_q <= prev_data;
			cdq_pkg::MODE_SHIFT_DOWN: data_q <= next_data;
			// the selected cell closes the ring by taking the head word
			cdq_pkg::MODE_ROTATE:     data_q <= hit ? head_data : next_data;
			default:                  data_q <= data_q;
		endcase
	end

endmodule

[hdl/cdq_chain.sv]
// row of deque cells with front at cell zero, plus the back read-out
// depends on cdq_pkg and cdq_cell
module cdq_chain (
	input  logic                              clk,
	input  cdq_pkg::cell_ctl_t                ctl,
	input  logic [cdq_pkg::IDX_W-1:0]         rd_idx,
	output logic signed [cdq_pkg::WORD_W-1:0] front_data,
	output logic signed [cdq_pkg::WORD_W-1:0] back_data
);

	logic signed [cdq_pkg::WORD_W-1:0] cell_data [cdq_pkg::DEPTH];
	logic [cdq_pkg::DEPTH-1:0][cdq_pkg::WORD_W-1:0] masked;

	for (genvar i = 0; i < cdq_pkg::DEPTH; i++) begin : g_cell
		logic signed [cdq_pkg::WORD_W-1:0] prev_w;
		logic signed [cdq_pkg::WORD_W-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = ctl.value;
		end else begin : g_mid
			assign prev_w = cell_data[i-1];
		end
		if (i == cdq_pkg::DEPTH - 1) begin : g_last
			assign next_w = cell_data[i];
		end else begin : g_inner
			assign next_w = cell_data[i+1];
		end

		cdq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (cdq_pkg::IDX_W'(i)),
			.prev_data (prev_w),
			.next_data (next_w),
			.head_data (cell_data[0]),
			.data      (cell_data[i])
		);

		assign masked[i] = (rd_idx == cdq_pkg::IDX_W'(i)) ? cell_data[i] : '0;
	end

	assign front_data = cell_data[0];

	// one-hot select, or-reduced across the row
	always_comb begin
		back_data = '0;
		for (int k = 0; k < cdq_pkg::DEPTH; k++) begin
			back_data = back_data | masked[k];
		end
	end

endmodule

[hdl/circular_deque_core.sv]
// circular deque core: command decode, element count and result registers over a cell chain
// a result appears on done in the cycle after its request is taken
// throughput: one request per cycle while not busy; list emits one element per cycle until all
// count elements are out, held by busy while the chain rotates through the stored elements
// reset clears count and control; stored words are not cleared. results cannot be stalled
// depends on cdq_pkg and cdq_chain
module circular_deque_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        command,
	input  logic signed [cdq_pkg::WORD_W-1:0] push_value,
	output logic                              done,
	output logic signed [cdq_pkg::WORD_W-1:0] item_value,
	output logic [1:0]                        status,
	output logic [cdq_pkg::OCC_W-1:0]         occupancy,
	output logic                              last_of_run
);

	logic [cdq_pkg::OCC_W-1:0]         count_q, count_d, count_m1;
	logic [cdq_pkg::IDX_W-1:0]         rem_q, rem_d, back_idx;
	logic                              busy_q, busy_d;
	logic                              done_q, done_d;
	logic                              last_q, last_d;
	cdq_pkg::status_t                  status_q, status_d;
	logic signed [cdq_pkg::WORD_W-1:0] item_q, item_d;
	logic signed [cdq_pkg::WORD_W-1:0] front_data, back_data;
	cdq_pkg::cell_ctl_t                ctl;
	cdq_pkg::cmd_t                     cmd;
	logic                              full, empty;

	assign cmd      = cdq_pkg::cmd_t'(command);
	assign count_m1 = count_q - cdq_pkg::OCC_W'(1);
	assign back_idx = count_m1[cdq_pkg::IDX_W-1:0];
	assign full     = (count_q == cdq_pkg::OCC_W'(cdq_pkg::DEPTH));
	assign empty    = (count_q == '0);

	cdq_chain u_chain (
		.clk        (clk),
		.ctl        (ctl),
		.rd_idx     (back_idx),
		.front_data (front_data),
		.back_data  (back_data)
	);

	always_comb begin
		ctl.mode  = cdq_pkg::MODE_HOLD;
		ctl.sel   = back_idx;
		ctl.value = push_value;
		count_d   = count_q;
		rem_d     = rem_q;
		busy_d    = busy_q;
		done_d    = 1'b0;
		last_d    = 1'b1;
		status_d  = cdq_pkg::ST_OK;
		item_d    = '0;
		if (busy_q) begin
			// list in progress: head of the chain is the next element
			done_d   = 1'b1;
			item_d   = front_data;
			ctl.mode = cdq_pkg::MODE_ROTATE;
			last_d   = (rem_q == cdq_pkg::IDX_W'(1));
			busy_d   = (rem_q != cdq_pkg::IDX_W'(1));
			rem_d    = rem_q - cdq_pkg::IDX_W'(1);
		end else if (start) begin
			done_d = 1'b1;
			if (cmd == cdq_pkg::CMD_PUSH_BACK || cmd == cdq_pkg::CMD_PUSH_FRONT) begin
				if (full) begin
					status_d = cdq_pkg::ST_OVER;
				end else begin
					count_d = count_q + cdq_pkg::OCC_W'(1);
					if (cmd == cdq_pkg::CMD_PUSH_BACK) begin
						ctl.mode = cdq_pkg::MODE_WRITE;
						ctl.sel  = count_q[cdq_pkg::IDX_W-1:0];
					end else begin
						ctl.mode = cdq_pkg::MODE_SHIFT_UP;
					end
				end
			end else if (empty) begin
				status_d = cdq_pkg::ST_UNDER;
			end else begin
				unique case (cmd)
					cdq_pkg::CMD_POP_BACK: begin
						item_d  = back_data;
						count_d = count_m1;
					end
					cdq_pkg::CMD_POP_FRONT: begin
						item_d   = front_data;
						count_d  = count_m1;
						ctl.mode = cdq_pkg::MODE_SHIFT_DOWN;
					end
					cdq_pkg::CMD_PEEK_BACK:  item_d = back_data;
					cdq_pkg::CMD_PEEK_FRONT: item_d = front_data;
					cdq_pkg::CMD_LIST: begin
						item_d   = front_data;
						ctl.mode = cdq_pkg::MODE_ROTATE;
						last_d   = (count_q == cdq_pkg::OCC_W'(1));
						busy_d   = (count_q != cdq_pkg::OCC_W'(1));
						rem_d    = back_idx;
					end
					default: item_d = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			rem_q   <= rem_d;
			busy_q  <= busy_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q   <= item_d;
		status_q <= status_d;
		last_q   <= last_d;
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign item_value  = item_q;
	assign status      = status_q;
	assign occupancy   = count_q;
	assign last_of_run = last_q;

endmodule

[hdl/cdq_checker.sv]
// port-level checks for circular_deque_core, bound onto the top level
// depends on cdq_pkg
module cdq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [2:0]                        command,
	input logic signed [cdq_pkg::WORD_W-1:0] push_value,
	input logic                              done,
	input logic signed [cdq_pkg::WORD_W-1:0] item_value,
	input logic [1:0]                        status,
	input logic [cdq_pkg::OCC_W-1:0]         occupancy,
	input logic                              last_of_run
);

	// every taken request answers on the next cycle
	a_req_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("request without result");

	// a list run keeps emitting until its last element
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last_of_run) |=> (done && busy == $past(busy) || done))
		else $error("list run broken");

	a_busy_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> done)
		else $error("busy without result");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cdq_pkg::ST_OVER) |->
		(occupancy == cdq_pkg::OCC_W'(cdq_pkg::DEPTH) && item_value == '0))
		else $error("overflow while not full");

	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cdq_pkg::ST_UNDER) |->
		(occupancy == '0 && item_value == '0 && last_of_run))
		else $error("underflow while not empty");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (.*);
